[hdl/crsm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shadow mask closing package
// Shared constants, register codes and the step record that travels from
// the classifier front end to the closing back end.
// ----------------------------------------------------------------------------
package crsm_pkg;

    localparam int MAX_WIDTH   = 2048;
    localparam int MAX_HEIGHT  = 2048;
    localparam int DIM_W       = 12;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT + 4);
    localparam int LAG_W       = $clog2(2 * MAX_WIDTH + 3);
    localparam int CNT_W       = $clog2(MAX_WIDTH * MAX_HEIGHT + 2 * MAX_WIDTH + 3);
    localparam int PIX_W       = 8;
    localparam int BLIM_W      = 9;
    localparam int THR_W       = 24;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [DIM_W-1:0]  RESET_WIDTH     = DIM_W'(640);
    localparam logic [DIM_W-1:0]  RESET_HEIGHT    = DIM_W'(480);
    localparam logic [BLIM_W-1:0] RESET_BLUE_LIM  = BLIM_W'(34);
    localparam logic [THR_W-1:0]  RESET_THRESHOLD = THR_W'(7093293);

    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH     = 2'd0,
        CFG_FRAME_HEIGHT    = 2'd1,
        CFG_BLUE_LIMIT      = 2'd2,
        CFG_RATIO_THRESHOLD = 2'd3
    } crsm_cfg_idx_t;

    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
    } crsm_edge_t;

    typedef struct packed {
        logic             raw;
        logic [COL_W-1:0] col;
        logic [COL_W-1:0] dcol;
        crsm_edge_t       dedge;
        crsm_edge_t       eedge;
        logic             emit;
        logic             last;
    } crsm_step_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] limit);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > limit) begin
            r = limit;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

[hdl/crsm_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Step queue
// Short first-in first-out buffer that decouples the classifier from the
// closing pipeline.
// ----------------------------------------------------------------------------
module crsm_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  crsm_pkg::crsm_step_t  din,
    output logic                  full,
    input  logic                  pop,
    output crsm_pkg::crsm_step_t  dout,
    output logic                  empty
);

    localparam int PTR_W = $clog2(crsm_pkg::QUEUE_DEPTH);
    localparam int LVL_W = $clog2(crsm_pkg::QUEUE_DEPTH + 1);

    crsm_pkg::crsm_step_t slot_reg [crsm_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [LVL_W-1:0] level_reg, level_next;

    assign full  = (level_reg == LVL_W'(crsm_pkg::QUEUE_DEPTH));
    assign empty = (level_reg == '0);
    assign dout  = slot_reg[rd_ptr_reg];

    always_comb begin
        level_next = level_reg;
        if (push && !pop) begin
            level_next = level_reg + LVL_W'(1);
        end else if (pop && !push) begin
            level_next = level_reg - LVL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            level_reg <= level_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

[hdl/crsm_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Classifier front end
// Holds the configuration, tracks the frame position, decides the raw
// shadow bit and turns pixels and drain ticks into pipeline steps.
// ----------------------------------------------------------------------------
module crsm_front (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic                                   s_action,
    input  logic [crsm_pkg::PIX_W-1:0]             s_blue,
    input  logic [crsm_pkg::PIX_W-1:0]             s_green,
    input  logic [crsm_pkg::PIX_W-1:0]             s_red,
    input  logic                                   cfg_valid,
    input  logic [crsm_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [crsm_pkg::CFG_DATA_W-1:0]        cfg_data,
    output logic                                   q_push,
    output crsm_pkg::crsm_step_t                   q_entry,
    input  logic                                   q_full
);

    localparam int CNT_W = crsm_pkg::CNT_W;
    localparam int COL_W = crsm_pkg::COL_W;
    localparam int ROW_W = crsm_pkg::ROW_W;
    localparam int LAG_W = crsm_pkg::LAG_W;
    localparam int DIM_W = crsm_pkg::DIM_W;

    typedef enum logic [1:0] {
        ST_RUN   = 2'b01,
        ST_FLUSH = 2'b10
    } front_state_t;

    front_state_t state_reg, state_next;
    logic [DIM_W-1:0]           width_reg, height_reg;
    logic [crsm_pkg::BLIM_W-1:0] blue_limit_reg;
    logic [crsm_pkg::THR_W-1:0]  thr_reg;
    logic [CNT_W-1:0]           total_reg, cnt_reg;
    logic [LAG_W-1:0]           lag_reg;
    logic [COL_W-1:0]           col_reg;
    logic [ROW_W-1:0]           row_reg;

    logic [CNT_W-1:0] end_pos, pos_idx;
    logic [COL_W-1:0] pos_col, wm1, dcol, ecol;
    logic [ROW_W-1:0] pos_row;
    logic [ROW_W:0]   rdo, reo, hgt;
    logic             frame_full, drain_live, is_pixel, restart, take, emit, raw;
    logic [crsm_pkg::PIX_W-1:0] max_rg;
    logic [31:0]      prod, lhs;
    logic [DIM_W-1:0] wnew, hnew;

    assign end_pos    = total_reg + CNT_W'(lag_reg);
    assign frame_full = (cnt_reg >= total_reg);
    assign drain_live = frame_full && (cnt_reg < end_pos);
    assign is_pixel   = (s_action == crsm_pkg::ACT_PIXEL);
    assign s_ready    = (state_reg == ST_RUN) && !q_full;
    assign take       = s_valid && s_ready;
    assign restart    = (state_reg == ST_RUN) && is_pixel && frame_full;

    assign pos_idx = restart ? '0 : cnt_reg;
    assign pos_col = restart ? '0 : col_reg;
    assign pos_row = restart ? '0 : row_reg;

    assign wm1  = COL_W'(width_reg - DIM_W'(1));
    assign hgt  = (ROW_W+1)'(height_reg);
    assign dcol = (pos_col != '0) ? pos_col - COL_W'(1) : wm1;
    assign ecol = (dcol != '0) ? dcol - COL_W'(1) : wm1;
    assign rdo  = (pos_col != '0) ? {1'b0, pos_row} + (ROW_W+1)'(1) : {1'b0, pos_row};
    assign reo  = (dcol != '0) ? rdo + (ROW_W+1)'(1) : rdo;
    assign emit = (pos_idx >= CNT_W'(lag_reg));

    assign max_rg = (s_red > s_green) ? s_red : s_green;
    assign prod   = 32'(thr_reg) * 32'(max_rg);
    assign lhs    = {s_blue, 24'd0};
    assign raw    = (state_reg == ST_RUN) && is_pixel
                    && ({1'b0, s_blue} < blue_limit_reg) && (lhs > prod);

    assign wnew = crsm_pkg::clamp_dim(cfg_data[DIM_W-1:0], DIM_W'(crsm_pkg::MAX_WIDTH));
    assign hnew = crsm_pkg::clamp_dim(cfg_data[DIM_W-1:0], DIM_W'(crsm_pkg::MAX_HEIGHT));

    always_comb begin
        if (state_reg == ST_RUN) begin
            q_push = take && (is_pixel || drain_live);
        end else begin
            q_push = !q_full;
        end
        q_entry.raw          = raw;
        q_entry.col          = pos_col;
        q_entry.dcol         = dcol;
        q_entry.dedge.top    = (rdo >= (ROW_W+1)'(3));
        q_entry.dedge.bottom = (rdo < hgt + (ROW_W+1)'(1));
        q_entry.dedge.left   = (dcol != '0);
        q_entry.dedge.right  = (dcol != wm1);
        q_entry.eedge.top    = (reo >= (ROW_W+1)'(5));
        q_entry.eedge.bottom = (reo < hgt + (ROW_W+1)'(3));
        q_entry.eedge.left   = (ecol != '0);
        q_entry.eedge.right  = (ecol != wm1);
        q_entry.emit         = emit;
        q_entry.last         = (pos_idx == end_pos - CNT_W'(1));
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_RUN: begin
                if (q_push && !is_pixel && !emit) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (q_push && emit) begin
                    state_next = ST_RUN;
                end
            end
            default: state_next = ST_RUN;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_RUN;
            width_reg      <= crsm_pkg::RESET_WIDTH;
            height_reg     <= crsm_pkg::RESET_HEIGHT;
            blue_limit_reg <= crsm_pkg::RESET_BLUE_LIM;
            thr_reg        <= crsm_pkg::RESET_THRESHOLD;
            total_reg      <= CNT_W'(640 * 480);
            lag_reg        <= LAG_W'(2 * 640 + 2);
            cnt_reg        <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
        end else if (cfg_valid) begin
            unique case (crsm_pkg::crsm_cfg_idx_t'(cfg_index))
                crsm_pkg::CFG_FRAME_WIDTH: begin
                    width_reg <= wnew;
                    total_reg <= CNT_W'(wnew) * CNT_W'(height_reg);
                    lag_reg   <= LAG_W'({wnew, 1'b0}) + LAG_W'(2);
                    cnt_reg   <= '0;
                    col_reg   <= '0;
                    row_reg   <= '0;
                    state_reg <= ST_RUN;
                end
                crsm_pkg::CFG_FRAME_HEIGHT: begin
                    height_reg <= hnew;
                    total_reg  <= CNT_W'(width_reg) * CNT_W'(hnew);
                    cnt_reg    <= '0;
                    col_reg    <= '0;
                    row_reg    <= '0;
                    state_reg  <= ST_RUN;
                end
                crsm_pkg::CFG_BLUE_LIMIT: begin
                    blue_limit_reg <= cfg_data[crsm_pkg::BLIM_W-1:0];
                end
                crsm_pkg::CFG_RATIO_THRESHOLD: begin
                    thr_reg <= cfg_data[crsm_pkg::THR_W-1:0];
                end
                default: begin
                    thr_reg <= thr_reg;
                end
            endcase
        end else begin
            state_reg <= state_next;
            if (q_push) begin
                cnt_reg <= pos_idx + CNT_W'(1);
                if (pos_col == wm1) begin
                    col_reg <= '0;
                    row_reg <= pos_row + ROW_W'(1);
                end else begin
                    col_reg <= pos_col + COL_W'(1);
                    row_reg <= pos_row;
                end
            end
        end
    end

endmodule

[hdl/crsm_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Closing back end
// Two line buffers and three 3x3 windows: the first stage dilates the raw
// mask and its complement, the second erodes the dilated masks.
// ----------------------------------------------------------------------------
module crsm_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_empty,
    input  crsm_pkg::crsm_step_t  q_entry,
    output logic                  q_pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_shadow_closed,
    output logic                  m_nonshadow_closed,
    output logic                  m_frame_last
);

    function automatic logic [8:0] win_mask(input crsm_pkg::crsm_edge_t e);
        logic [2:0] rows;
        logic [8:0] m;
        rows = {e.top, 1'b1, e.bottom};
        m    = {rows & {3{e.left}}, rows, rows & {3{e.right}}};
        return m;
    endfunction

    logic [1:0] raw_mem [crsm_pkg::MAX_WIDTH];
    logic [3:0] dil_mem [crsm_pkg::MAX_WIDTH];

    crsm_pkg::crsm_step_t s1_reg, s2_reg, s3_reg, s4_reg;
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic [1:0] raw_rd_reg;
    logic [3:0] dil_rd_reg;
    logic [1:0] dil3_reg;
    logic [8:0] rwin_reg, dwin_s_reg, dwin_n_reg;
    logic       out_valid_reg, out_s_reg, out_n_reg, out_last_reg;

    logic       adv, raw_wr, dil_wr, dil_rd;
    logic [1:0] raw_wdata;
    logic [3:0] dil_wdata;
    logic [8:0] dmask, emask;
    logic [1:0] dil_now;
    logic       close_s, close_n;

    assign adv   = !out_valid_reg || m_ready;
    assign q_pop = adv && !q_empty;

    assign raw_wr    = adv && v1_reg;
    assign raw_wdata = {raw_rd_reg[0], s1_reg.raw};
    assign dil_rd    = adv && v2_reg;
    assign dil_wr    = adv && v3_reg;
    assign dil_wdata = {dil_rd_reg[1:0], dil3_reg};

    assign dmask   = win_mask(s2_reg.dedge);
    assign dil_now = {|(rwin_reg & dmask), |(~rwin_reg & dmask)};
    assign emask   = win_mask(s4_reg.eedge);
    assign close_s = &(dwin_s_reg | ~emask);
    assign close_n = &(dwin_n_reg | ~emask);

    assign m_valid            = out_valid_reg;
    assign m_shadow_closed    = out_s_reg;
    assign m_nonshadow_closed = out_n_reg;
    assign m_frame_last       = out_last_reg;

    always_ff @(posedge aclk) begin
        if (raw_wr) begin
            raw_mem[s1_reg.col] <= raw_wdata;
        end
        if (q_pop) begin
            if (raw_wr && (s1_reg.col == q_entry.col)) begin
                raw_rd_reg <= raw_wdata;
            end else begin
                raw_rd_reg <= raw_mem[q_entry.col];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (dil_wr) begin
            dil_mem[s3_reg.dcol] <= dil_wdata;
        end
        if (dil_rd) begin
            if (dil_wr && (s3_reg.dcol == s2_reg.dcol)) begin
                dil_rd_reg <= dil_wdata;
            end else begin
                dil_rd_reg <= dil_mem[s2_reg.dcol];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_reg   <= q_entry;
            s2_reg   <= s1_reg;
            s3_reg   <= s2_reg;
            s4_reg   <= s3_reg;
            dil3_reg <= dil_now;
            out_s_reg    <= close_s;
            out_n_reg    <= close_n;
            out_last_reg <= s4_reg.last;
        end
        if (raw_wr) begin
            rwin_reg <= {rwin_reg[5:0], raw_rd_reg[1], raw_rd_reg[0], s1_reg.raw};
        end
        if (dil_wr) begin
            dwin_s_reg <= {dwin_s_reg[5:0], dil_rd_reg[3], dil_rd_reg[1], dil3_reg[1]};
            dwin_n_reg <= {dwin_n_reg[5:0], dil_rd_reg[2], dil_rd_reg[0], dil3_reg[0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            v1_reg        <= q_pop;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            out_valid_reg <= v4_reg && s4_reg.emit;
        end
    end

endmodule

[hdl/color_ratio_shadow_mask_closing.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Color ratio shadow mask with 3x3 closing
// Throughput: one pixel or drain tick per cycle while the queue has room; a
// drain tick that arrives after a full frame while fewer than 2*(width+1)
// steps have entered holds the input until that many steps are queued.
// Output: the result for a pixel is made once 2*(width+1) later steps have
// entered, then passes through the queue and the pipeline. Reset: synchronous,
// active low, loads the default configuration; the line buffers are not cleared.
// ----------------------------------------------------------------------------
module color_ratio_shadow_mask_closing (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic                                   s_action,
    input  logic [crsm_pkg::PIX_W-1:0]             s_blue,
    input  logic [crsm_pkg::PIX_W-1:0]             s_green,
    input  logic [crsm_pkg::PIX_W-1:0]             s_red,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [crsm_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [crsm_pkg::CFG_DATA_W-1:0]        cfg_data,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic                                   m_shadow_closed,
    output logic                                   m_nonshadow_closed,
    output logic                                   m_frame_last
);

    crsm_pkg::crsm_step_t push_entry, head_entry;
    logic q_push, q_pop, q_full, q_empty;

    assign cfg_ready = 1'b1;

    crsm_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_action  (s_action),
        .s_blue    (s_blue),
        .s_green   (s_green),
        .s_red     (s_red),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_push    (q_push),
        .q_entry   (push_entry),
        .q_full    (q_full)
    );

    crsm_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (push_entry),
        .full    (q_full),
        .pop     (q_pop),
        .dout    (head_entry),
        .empty   (q_empty)
    );

    crsm_back u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .q_empty            (q_empty),
        .q_entry            (head_entry),
        .q_pop              (q_pop),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_shadow_closed    (m_shadow_closed),
        .m_nonshadow_closed (m_nonshadow_closed),
        .m_frame_last       (m_frame_last)
    );

`ifndef SYNTH
    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("step pushed into a full queue");

    a_queue_state: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_full && q_empty))
        else $error("queue both full and empty");

    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");
`endif

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shadow mask closing testbench
// Streams pixel frames and drain ticks through the block under several frame
// sizes and thresholds, predicts the closed shadow and non-shadow masks with
// its own line store model, and checks every result transfer in order.
// ----------------------------------------------------------------------------
module testbench;

    localparam int TIMEOUT_CYCLES = 2000000;

    typedef struct {
        logic       act;
        logic [7:0] b;
        logic [7:0] g;
        logic [7:0] r;
    } pixel_item_t;

    typedef struct {
        logic shadow;
        logic nonshadow;
        logic last;
    } mask_out_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_action = crsm_pkg::ACT_PIXEL;
    logic [crsm_pkg::PIX_W-1:0] s_blue = '0;
    logic [crsm_pkg::PIX_W-1:0] s_green = '0;
    logic [crsm_pkg::PIX_W-1:0] s_red = '0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [crsm_pkg::CFG_IDX_W-1:0] cfg_index = crsm_pkg::CFG_FRAME_WIDTH;
    logic [crsm_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_shadow_closed;
    logic m_nonshadow_closed;
    logic m_frame_last;

    color_ratio_shadow_mask_closing dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predictor state.
    bit                          raw_rows [0:7][0:crsm_pkg::MAX_WIDTH-1];
    int unsigned                 in_pos;
    int unsigned                 out_pos;
    logic [crsm_pkg::DIM_W-1:0]  width_reg;
    logic [crsm_pkg::DIM_W-1:0]  height_reg;
    logic [crsm_pkg::BLIM_W-1:0] blue_lim_reg;
    logic [crsm_pkg::THR_W-1:0]  thresh_reg;

    pixel_item_t pixel_queue[$];
    mask_out_t   mask_queue[$];
    int          errors = 0;
    bit          quiet_send = 0;
    bit          quiet_recv = 0;
    int          items_sent = 0;

    function automatic int unsigned dim_of(logic [crsm_pkg::DIM_W-1:0] v, int unsigned lim);
        if (v == 0) return 1;
        if (v > lim) return lim;
        return v;
    endfunction

    function automatic bit dilate_at(int r, int c, int w, int h, bit ws);
        int r0, r1, c0, c1;
        r0 = (r > 0) ? r - 1 : 0;
        r1 = (r + 1 < h) ? r + 1 : r;
        c0 = (c > 0) ? c - 1 : 0;
        c1 = (c + 1 < w) ? c + 1 : c;
        for (int i = r0; i <= r1; i++)
            for (int j = c0; j <= c1; j++)
                if ((raw_rows[i & 7][j] ^ !ws) == 1'b1) return 1'b1;
        return 1'b0;
    endfunction

    function automatic bit close_at(int r, int c, int w, int h, bit ws);
        int r0, r1, c0, c1;
        r0 = (r > 0) ? r - 1 : 0;
        r1 = (r + 1 < h) ? r + 1 : r;
        c0 = (c > 0) ? c - 1 : 0;
        c1 = (c + 1 < w) ? c + 1 : c;
        for (int i = r0; i <= r1; i++)
            for (int j = c0; j <= c1; j++)
                if (!dilate_at(i, j, w, h, ws)) return 1'b0;
        return 1'b1;
    endfunction

    function automatic void emit_mask(int unsigned q, int unsigned w, int unsigned h);
        mask_out_t m;
        m.shadow    = close_at(q / w, q % w, w, h, 1'b1);
        m.nonshadow = close_at(q / w, q % w, w, h, 1'b0);
        m.last      = (q == w * h - 1);
        mask_queue.push_back(m);
        out_pos = q + 1;
    endfunction

    function automatic void predict_mask(pixel_item_t it);
        int unsigned w, h, total, lag, p;
        longint unsigned mx;
        bit s;
        w = dim_of(width_reg, crsm_pkg::MAX_WIDTH);
        h = dim_of(height_reg, crsm_pkg::MAX_HEIGHT);
        total = w * h;
        lag = 2 * (w + 1);
        if (it.act == crsm_pkg::ACT_DRAIN) begin
            if (in_pos >= total && out_pos < total) emit_mask(out_pos, w, h);
            return;
        end
        if (in_pos >= total) begin
            in_pos = 0;
            out_pos = 0;
        end
        mx = (it.r > it.g) ? it.r : it.g;
        s = (it.b < blue_lim_reg) &&
            ((longint'(it.b) << 24) > longint'(thresh_reg) * mx);
        p = in_pos;
        raw_rows[(p / w) & 7][p % w] = s;
        in_pos = p + 1;
        if (p >= lag) emit_mask(p - lag, w, h);
    endfunction

    // Driver.
    pixel_item_t cur_item;
    int          send_gap = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready) predict_mask(cur_item);
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_valid <= 1'b0;
                end else if (pixel_queue.size() > 0) begin
                    cur_item = pixel_queue.pop_front();
                    s_action <= cur_item.act;
                    s_blue <= cur_item.b;
                    s_green <= cur_item.g;
                    s_red <= cur_item.r;
                    s_valid <= 1'b1;
                    send_gap <= quiet_send ? 0 : $urandom_range(0, 14);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor.
    int        recv_gap = 0;
    mask_out_t want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (mask_queue.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("Unexpected result transfer: shadow=%0b nonshadow=%0b last=%0b",
                                 m_shadow_closed, m_nonshadow_closed, m_frame_last);
                end else begin
                    want = mask_queue.pop_front();
                    if (m_shadow_closed !== want.shadow ||
                        m_nonshadow_closed !== want.nonshadow ||
                        m_frame_last !== want.last) begin
                        errors++;
                        if (errors <= 10)
                            $display("Mismatch: expected %0b/%0b/%0b, got %0b/%0b/%0b",
                                     want.shadow, want.nonshadow, want.last,
                                     m_shadow_closed, m_nonshadow_closed, m_frame_last);
                    end
                end
            end
            if (recv_gap > 0) begin
                m_ready <= 1'b0;
                recv_gap <= recv_gap - 1;
            end else begin
                m_ready <= 1'b1;
                if (m_valid && m_ready && !quiet_recv) recv_gap <= $urandom_range(0, 14);
            end
        end
    end

    int cycle_count = 0;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > TIMEOUT_CYCLES) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic wait_drained();
        do @(posedge aclk);
        while (pixel_queue.size() > 0 || s_valid || send_gap > 0 || mask_queue.size() > 0);
    endtask

    task automatic write_reg(crsm_pkg::crsm_cfg_idx_t idx,
                             logic [crsm_pkg::CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        do @(posedge aclk);
        while (!cfg_ready);
        case (idx)
            crsm_pkg::CFG_FRAME_WIDTH: begin
                width_reg = data[crsm_pkg::DIM_W-1:0];
                in_pos = 0;
                out_pos = 0;
            end
            crsm_pkg::CFG_FRAME_HEIGHT: begin
                height_reg = data[crsm_pkg::DIM_W-1:0];
                in_pos = 0;
                out_pos = 0;
            end
            crsm_pkg::CFG_BLUE_LIMIT: blue_lim_reg = data[crsm_pkg::BLIM_W-1:0];
            default: thresh_reg = data[crsm_pkg::THR_W-1:0];
        endcase
    endtask

    task automatic configure(int w, int h, int blim, int thr);
        wait_drained();
        repeat (20) @(posedge aclk);
        write_reg(crsm_pkg::CFG_FRAME_WIDTH,
                  crsm_pkg::CFG_DATA_W'({$urandom_range(0, 4095), w[11:0]}));
        write_reg(crsm_pkg::CFG_FRAME_HEIGHT,
                  crsm_pkg::CFG_DATA_W'({$urandom_range(0, 4095), h[11:0]}));
        write_reg(crsm_pkg::CFG_BLUE_LIMIT,
                  crsm_pkg::CFG_DATA_W'({$urandom_range(0, 32767), blim[8:0]}));
        write_reg(crsm_pkg::CFG_RATIO_THRESHOLD, thr[23:0]);
        cfg_valid <= 1'b0;
        quiet_send = ($urandom_range(0, 3) == 0);
        quiet_recv = ($urandom_range(0, 3) == 0);
    endtask

    function automatic void push_item(logic act, int b, int g, int r);
        pixel_item_t it;
        it.act = act;
        it.b = b[7:0];
        it.g = g[7:0];
        it.r = r[7:0];
        pixel_queue.push_back(it);
        items_sent++;
    endfunction

    function automatic void push_random_pixel();
        int b, mx;
        case ($urandom_range(0, 3))
            0: push_item(crsm_pkg::ACT_PIXEL, $urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 255));
            1: begin
                b = $urandom_range(0, 45);
                mx = $urandom_range(0, 3 * b + 2);
                push_item(crsm_pkg::ACT_PIXEL, b, $urandom_range(0, mx),
                          $urandom_range(0, mx));
            end
            2: push_item(crsm_pkg::ACT_PIXEL, $urandom_range(0, 1) * 255,
                         $urandom_range(0, 1) * 255, $urandom_range(0, 1) * 255);
            default: begin
                b = $urandom_range(0, 255);
                push_item(crsm_pkg::ACT_PIXEL, b, $urandom_range(0, b), $urandom_range(0, b));
            end
        endcase
    endfunction

    initial begin
        int w, h, blim, thr, total, n_drain;
        width_reg = crsm_pkg::RESET_WIDTH;
        height_reg = crsm_pkg::RESET_HEIGHT;
        blue_lim_reg = crsm_pkg::RESET_BLUE_LIM;
        thresh_reg = crsm_pkg::RESET_THRESHOLD;
        in_pos = 0;
        out_pos = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // A 3x3 frame, every blue value passes, zero threshold.
        configure(3, 3, 256, 0);
        push_item(crsm_pkg::ACT_DRAIN, 255, 255, 255);
        push_item(crsm_pkg::ACT_PIXEL, 0, 0, 0);
        push_item(crsm_pkg::ACT_PIXEL, 255, 255, 255);
        push_item(crsm_pkg::ACT_PIXEL, 1, 0, 0);
        push_item(crsm_pkg::ACT_PIXEL, 255, 0, 0);
        push_item(crsm_pkg::ACT_PIXEL, 0, 255, 255);
        push_item(crsm_pkg::ACT_PIXEL, 128, 255, 0);
        push_item(crsm_pkg::ACT_PIXEL, 170, 85, 170);
        push_item(crsm_pkg::ACT_PIXEL, 85, 170, 85);
        push_item(crsm_pkg::ACT_PIXEL, 255, 0, 255);
        repeat (10) push_item(crsm_pkg::ACT_DRAIN, 0, 0, 0);

        // Width of zero clamps to one; a pixel after a full frame restarts it.
        configure(0, 1, 0, 24'hFFFFFF);
        push_item(crsm_pkg::ACT_PIXEL, 0, 0, 0);
        push_item(crsm_pkg::ACT_DRAIN, 0, 0, 0);
        push_item(crsm_pkg::ACT_DRAIN, 0, 0, 0);
        push_item(crsm_pkg::ACT_PIXEL, 255, 0, 0);
        push_item(crsm_pkg::ACT_PIXEL, 5, 255, 255);
        push_item(crsm_pkg::ACT_DRAIN, 0, 0, 0);

        // Oversized width clamps to the widest row; a partial frame yields nothing.
        configure(4095, 1, 34, 7093293);
        repeat (100) push_random_pixel();
        repeat (4) push_item(crsm_pkg::ACT_DRAIN, 0, 0, 0);

        while (items_sent < 900) begin
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 8);
            case ($urandom_range(0, 3))
                0: blim = 256;
                1: blim = 34;
                default: blim = $urandom_range(0, 256);
            endcase
            case ($urandom_range(0, 3))
                0: thr = 7093293;
                1: thr = $urandom_range(0, 24'hFFFFFF);
                2: thr = $urandom_range(0, 1) * 24'hFFFFFF;
                default: thr = $urandom_range(1000000, 20000000) & 24'hFFFFFF;
            endcase
            configure(w, h, blim, thr);
            total = w * h;
            repeat ($urandom_range(1, 3)) begin
                for (int i = 0; i < total; i++) begin
                    if ($urandom_range(0, 19) == 0) push_item(crsm_pkg::ACT_DRAIN, 0, 0, 0);
                    push_random_pixel();
                end
                if ($urandom_range(0, 3) == 0) wait_drained();
                n_drain = 2 * (w + 1) + 1;
                if ($urandom_range(0, 9) == 0) n_drain = $urandom_range(0, n_drain);
                repeat (n_drain) push_item(crsm_pkg::ACT_DRAIN, 0, 0, 0);
            end
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, total)) push_random_pixel();
        end

        wait_drained();
        repeat (50) @(posedge aclk);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[files.f]
hdl/crsm_pkg.sv
hdl/crsm_queue.sv
hdl/crsm_front.sv
hdl/crsm_back.sv
hdl/color_ratio_shadow_mask_closing.sv
sim/testbench.sv
